// File: rtl/core/tdbl_pkg.sv
// Shared constants, widths and helpers for the tree distance block.
// No dependencies; the top module imports this package.
package tdbl_pkg;

	// The node count is a power of two, so a node index is just the low bits of a field.
	localparam int NODE_W    = 10;
	localparam int NODES     = 1 << NODE_W;
	localparam int LEVELS    = 10;
	localparam int LVL_W     = (LEVELS > 1) ? $clog2(LEVELS) : 1;
	localparam int ANC_DEPTH = NODES * LEVELS;
	localparam int ANC_AW    = $clog2(ANC_DEPTH);
	localparam int DEPTH_W   = 10;
	localparam int LEN_W     = 11;
	localparam int K_W       = 16;

	localparam logic [DEPTH_W-1:0] DEPTH_MAX = '1;
	localparam logic               FUNC_ADD  = 1'b0;
	localparam logic               FUNC_QRY  = 1'b1;

	// Flat address of the 2^lvl-th ancestor entry of a node.
	function automatic logic [ANC_AW-1:0] anc_addr(input logic [NODE_W-1:0] node,
			input logic [LVL_W-1:0] lvl);
		anc_addr = ANC_AW'(node) * ANC_AW'(LEVELS) + ANC_AW'(lvl);
	endfunction

endpackage

// File: rtl/core/tdbl_in_if.sv
// Request channel of the tree distance block: valid/ready plus the item fields.
// Depends on nothing.
interface tdbl_in_if;
	logic        valid;
	logic        ready;
	logic        func;
	logic [9:0]  new_node;
	logic [9:0]  parent_node;
	logic        has_parent;
	logic [9:0]  first_node;
	logic [9:0]  second_node;

	modport source (output valid, func, new_node, parent_node, has_parent, first_node,
		second_node, input ready);
	modport sink (input valid, func, new_node, parent_node, has_parent, first_node,
		second_node, output ready);
endinterface

// File: rtl/core/tdbl_out_if.sv
// Result channel of the tree distance block: valid/ready plus the result fields.
// Depends on nothing.
interface tdbl_out_if;
	logic        valid;
	logic        ready;
	logic [10:0] path_length;
	logic [9:0]  meeting_node;

	modport source (output valid, path_length, meeting_node, input ready);
	modport sink (input valid, path_length, meeting_node, output ready);
endinterface

// File: rtl/core/tree_distance_binary_lifting_top.sv
// Add item: read and depth steps, then the fill one level a cycle; ready again after the top level.
// Query item: read, compare, lift, meet, climb and parent steps, then the length step; the climb and
// parent steps are skipped when the lifted node is already the other node. Ready returns with the
// result; a result still held at the output stalls the next query in its last step. One item at a time.
// Reset (arst_n low, asynchronous) clears the sequencer and the result valid; tables hold junk.
// Depends on tdbl_pkg, tdbl_in_if and tdbl_out_if.
module tree_distance_binary_lifting_top
	import tdbl_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	tdbl_in_if.sink     req,
	tdbl_out_if.source  res
);

	// The sequencer walks one item through the two tables. Add items fill the ancestor row of
	// the new node level by level; each level reads the previous level of the previous ancestor.
	// Query items lift the deeper node over the set bits of the depth difference, then climb
	// both nodes from the top level down, and finally look up the depth of the meeting node.
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_A_RD,
		ST_A_DEP,
		ST_A_FILL,
		ST_Q_RD,
		ST_Q_CMP,
		ST_Q_LIFT,
		ST_Q_MEET,
		ST_Q_CLIMB,
		ST_Q_PAR,
		ST_Q_LEN
	} state_t;

	localparam logic [LVL_W-1:0] LVL_TOP = LVL_W'(LEVELS - 1);

	state_t              state_q;
	logic [LVL_W-1:0]    lvl_q;
	logic                pend_q;
	logic                fwd_q;
	logic                res_v_q;

	logic [NODE_W-1:0]   v_q;
	logic [NODE_W-1:0]   p_q;
	logic                hp_q;
	logic [NODE_W-1:0]   a_q;
	logic [NODE_W-1:0]   b_q;
	logic [NODE_W-1:0]   l_q;
	logic [LEVELS-1:0]   k_q;
	logic [LEN_W-1:0]    dsum_q;
	logic [LEN_W-1:0]    res_len_q;
	logic [NODE_W-1:0]   res_node_q;

	// Tables. The ancestor table has two read ports for the paired climb reads.
	logic [NODE_W-1:0]   anc_mem [ANC_DEPTH];
	logic [DEPTH_W-1:0]  dep_mem [NODES];

	logic [ANC_AW-1:0]   anc_ra;
	logic [ANC_AW-1:0]   anc_rb;
	logic [ANC_AW-1:0]   anc_wa;
	logic [NODE_W-1:0]   anc_wd;
	logic                anc_we;
	logic [NODE_W-1:0]   anc_rd_a;
	logic [NODE_W-1:0]   anc_rd_b;

	logic [NODE_W-1:0]   dep_ra;
	logic [NODE_W-1:0]   dep_rb;
	logic [NODE_W-1:0]   dep_wa;
	logic [DEPTH_W-1:0]  dep_wd;
	logic                dep_we;
	logic [DEPTH_W-1:0]  dep_rd_a;
	logic [DEPTH_W-1:0]  dep_rd_b;

	// Shared datapath values.
	logic [NODE_W-1:0]   root_anc;
	logic [NODE_W-1:0]   fill_val;
	logic [NODE_W-1:0]   a_eff;
	logic                climb_diff;
	logic [NODE_W-1:0]   na;
	logic [NODE_W-1:0]   nb;
	logic                deeper_b;
	logic [K_W-1:0]      ddiff;
	logic [LEN_W-1:0]    twice_l;
	logic [LEN_W-1:0]    len_val;
	logic                res_free;
	logic                accept;

	assign accept   = req.valid && req.ready;
	assign req.ready = (state_q == ST_IDLE);
	assign res.valid = res_v_q;
	assign res.path_length  = res_len_q;
	assign res.meeting_node = res_node_q;
	assign res_free = !res_v_q || res.ready;

	// Level zero of a new node: its parent, or the node itself for the root.
	assign root_anc = hp_q ? p_q : v_q;
	// When the ancestor read hit the entry written in the same cycle, the value is the node.
	assign fill_val = fwd_q ? v_q : anc_rd_a;
	// The lifted node is the last read result when that level's bit was set.
	assign a_eff = pend_q ? anc_rd_a : a_q;
	assign climb_diff = (anc_rd_a != anc_rd_b);
	assign na = climb_diff ? anc_rd_a : a_q;
	assign nb = climb_diff ? anc_rd_b : b_q;
	assign deeper_b = (dep_rd_a < dep_rd_b);
	assign ddiff = deeper_b ? (K_W'(dep_rd_b) - K_W'(dep_rd_a))
		: (K_W'(dep_rd_a) - K_W'(dep_rd_b));
	assign twice_l = {dep_rd_a, 1'b0};
	// A negative length can only come from an inconsistent tree; it is clamped to zero.
	assign len_val = (dsum_q < twice_l) ? '0 : (dsum_q - twice_l);

	// Memory port selection for each sequencer step.
	always_comb begin
		anc_ra = anc_addr(a_q, '0);
		anc_rb = anc_addr(b_q, '0);
		anc_wa = anc_addr(v_q, '0);
		anc_wd = root_anc;
		anc_we = 1'b0;
		dep_ra = a_q;
		dep_rb = b_q;
		dep_wa = v_q;
		dep_wd = '0;
		dep_we = 1'b0;
		unique case (state_q)
			ST_A_RD: begin
				dep_ra = p_q;
				anc_we = 1'b1;
			end
			ST_A_DEP: begin
				anc_ra = anc_addr(root_anc, '0);
				dep_we = 1'b1;
				if (!hp_q) begin
					dep_wd = '0;
				end else if (dep_rd_a == DEPTH_MAX) begin
					dep_wd = DEPTH_MAX;
				end else begin
					dep_wd = dep_rd_a + DEPTH_W'(1);
				end
			end
			ST_A_FILL: begin
				anc_we = 1'b1;
				anc_wa = anc_addr(v_q, lvl_q);
				anc_wd = fill_val;
				anc_ra = anc_addr(fill_val, lvl_q);
			end
			ST_Q_LIFT: begin
				anc_ra = anc_addr(a_eff, lvl_q);
			end
			ST_Q_MEET: begin
				anc_ra = anc_addr(a_eff, LVL_TOP);
				anc_rb = anc_addr(b_q, LVL_TOP);
				dep_ra = a_eff;
			end
			ST_Q_CLIMB: begin
				// The last climb level reads the parent of the final node.
				if (lvl_q == '0) begin
					anc_ra = anc_addr(na, '0);
					anc_rb = anc_addr(nb, '0);
				end else begin
					anc_ra = anc_addr(na, lvl_q - LVL_W'(1));
					anc_rb = anc_addr(nb, lvl_q - LVL_W'(1));
				end
			end
			ST_Q_PAR: begin
				dep_ra = anc_rd_a;
			end
			ST_Q_LEN: begin
				dep_ra = l_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (anc_we) begin
			anc_mem[anc_wa] <= anc_wd;
		end
		anc_rd_a <= anc_mem[anc_ra];
		anc_rd_b <= anc_mem[anc_rb];
	end

	always_ff @(posedge clk) begin
		if (dep_we) begin
			dep_mem[dep_wa] <= dep_wd;
		end
		dep_rd_a <= dep_mem[dep_ra];
		dep_rd_b <= dep_mem[dep_rb];
	end

	// Sequencer state and the result valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			lvl_q   <= '0;
			pend_q  <= 1'b0;
			fwd_q   <= 1'b0;
			res_v_q <= 1'b0;
		end else begin
			// A new result is loaded when the register is free; otherwise a taken one clears.
			if (state_q == ST_Q_LEN && res_free) begin
				res_v_q <= 1'b1;
			end else if (res.ready) begin
				res_v_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= (req.func == FUNC_ADD) ? ST_A_RD : ST_Q_RD;
					end
				end
				ST_A_RD: begin
					state_q <= ST_A_DEP;
				end
				ST_A_DEP: begin
					lvl_q   <= LVL_W'(1);
					fwd_q   <= 1'b0;
					state_q <= (LEVELS > 1) ? ST_A_FILL : ST_IDLE;
				end
				ST_A_FILL: begin
					fwd_q <= (fill_val == v_q);
					lvl_q <= lvl_q + LVL_W'(1);
					if (lvl_q == LVL_TOP) begin
						state_q <= ST_IDLE;
					end
				end
				ST_Q_RD: begin
					state_q <= ST_Q_CMP;
				end
				ST_Q_CMP: begin
					lvl_q   <= '0;
					pend_q  <= 1'b0;
					state_q <= ST_Q_LIFT;
				end
				ST_Q_LIFT: begin
					pend_q <= k_q[lvl_q];
					lvl_q  <= lvl_q + LVL_W'(1);
					if (lvl_q == LVL_TOP) begin
						state_q <= ST_Q_MEET;
					end
				end
				ST_Q_MEET: begin
					lvl_q   <= LVL_TOP;
					state_q <= (a_eff == b_q) ? ST_Q_LEN : ST_Q_CLIMB;
				end
				ST_Q_CLIMB: begin
					lvl_q <= lvl_q - LVL_W'(1);
					if (lvl_q == '0) begin
						state_q <= ST_Q_PAR;
					end
				end
				ST_Q_PAR: begin
					state_q <= ST_Q_LEN;
				end
				ST_Q_LEN: begin
					if (res_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Working nodes, depth bookkeeping and result payload.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				v_q  <= req.new_node[NODE_W-1:0];
				p_q  <= req.parent_node[NODE_W-1:0];
				hp_q <= req.has_parent;
				a_q  <= req.first_node[NODE_W-1:0];
				b_q  <= req.second_node[NODE_W-1:0];
			end
			ST_Q_CMP: begin
				// The deeper node goes to a_q; only the low LEVELS bits of the difference count.
				if (deeper_b) begin
					a_q <= b_q;
					b_q <= a_q;
				end
				k_q    <= ddiff[LEVELS-1:0];
				dsum_q <= LEN_W'(dep_rd_a) + LEN_W'(dep_rd_b);
			end
			ST_Q_LIFT: begin
				a_q <= a_eff;
			end
			ST_Q_MEET: begin
				a_q <= a_eff;
				l_q <= a_eff;
			end
			ST_Q_CLIMB: begin
				a_q <= na;
				b_q <= nb;
			end
			ST_Q_PAR: begin
				l_q <= anc_rd_a;
			end
			ST_Q_LEN: begin
				if (res_free) begin
					res_len_q  <= len_val;
					res_node_q <= l_q;
				end
			end
			default: begin
			end
		endcase
	end

`ifndef SYNTHESIS
	// An accepted item keeps the block busy in the following cycle.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready) |=> !req.ready)
		else $error("request accepted twice in a row");

	// A result appears only after the final depth lookup of a query.
	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res.valid) |-> $past(state_q == ST_Q_LEN))
		else $error("result raised outside the length step");

	// While climbing, the two nodes never coincide.
	a_climb_distinct: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_Q_CLIMB) |-> (a_q != b_q))
		else $error("climb reached equal nodes");

	// A held result is not overwritten before it is taken.
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(res.valid && !res.ready) |=> (res.valid && $stable(res.path_length)
			&& $stable(res.meeting_node)))
		else $error("stalled result changed");
`endif

endmodule
